// File: rtl/cfdd_pkg.sv
// ----------------------------------------------------------------------------
// cfdd_pkg
// Shared types and constants for the command frame deframer and decoder.
// ----------------------------------------------------------------------------
package cfdd_pkg;

  // Framing bytes
  localparam logic [7:0] StartByte  = 8'h21;
  localparam logic [7:0] EndByte    = 8'h3B;
  localparam logic [7:0] TypeByte   = 8'hC0;
  localparam int unsigned TypeLength = 7;

  // Depth of the queue between deframer and decoder
  localparam int unsigned QueueDepth = 2;

  // Command byte (frame byte 4) bit positions
  localparam int unsigned CtrlBit     = 0;
  localparam int unsigned InteriorBit = 1;
  localparam int unsigned NavBit      = 2;
  localparam int unsigned BattOneBit  = 3;
  localparam int unsigned BattTwoBit  = 4;

  // Battery selection codes
  localparam logic [1:0] BattNone = 2'd0;
  localparam logic [1:0] BattOne  = 2'd1;
  localparam logic [1:0] BattTwo  = 2'd2;

  // Gear codes (frame byte 3, bits 2:0)
  localparam logic [2:0] GearLow     = 3'd1;
  localparam logic [2:0] GearNeutral = 3'd4;
  localparam logic [2:0] GearHigh    = 3'd5;

  // Velocity field (frame byte 3, bits 5:3) and resulting modes
  localparam logic [2:0] VelSelTurtle  = 3'b001;
  localparam logic [2:0] VelSelRabbit  = 3'b010;
  localparam logic [2:0] VelSelLeopard = 3'b100;
  localparam logic [1:0] SpeedTurtle   = 2'd0;
  localparam logic [1:0] SpeedRabbit   = 2'd1;
  localparam logic [1:0] SpeedLeopard  = 2'd2;

  // Frame bytes the decoder needs
  typedef struct packed {
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
  } cfdd_frame_t;

  // Deframer to queue
  typedef struct packed {
    logic        valid;
    cfdd_frame_t frame;
  } cfdd_push_t;

  // Queue head to decoder
  typedef struct packed {
    logic        valid;
    cfdd_frame_t frame;
  } cfdd_head_t;

  // Decoded result word
  typedef struct packed {
    logic       interior_toggle;
    logic       navigation_toggle;
    logic       battery_one_on;
    logic       battery_two_on;
    logic [1:0] battery_selected;
    logic       battery_changed;
    logic       control_on;
    logic [2:0] gear_now;
    logic       neutral_seen;
    logic [1:0] speed_mode;
    logic       speed_changed;
    logic [7:0] wheel_direction;
  } cfdd_result_t;

endpackage

// File: rtl/cfdd_if.sv
// ----------------------------------------------------------------------------
// cfdd_if
// Valid/ready channels: received byte stream and decoded result words.
// ----------------------------------------------------------------------------
interface cfdd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cfdd_result_if;
  import cfdd_pkg::*;
  logic         valid;
  logic         ready;
  cfdd_result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cfdd_front.sv
// ----------------------------------------------------------------------------
// cfdd_front
// Deframer: tracks frame position, keeps bytes 2..4 and pushes a closed frame.
// ----------------------------------------------------------------------------
module cfdd_front #(
  parameter int unsigned BufferBytes = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  cfdd_byte_if.sink           rx_i,
  input  logic                full_i,
  output cfdd_pkg::cfdd_push_t push_o
);
  import cfdd_pkg::*;

  localparam int unsigned CntW = $clog2(BufferBytes);

  logic            receiving_q, receiving_d;
  logic [CntW-1:0] count_q, count_d;
  logic            len_ok_q, len_ok_d;
  cfdd_frame_t     frame_q, frame_d;
  logic            accept;

  // Take a word whenever the queue can hold a possible frame
  assign rx_i.ready = !full_i;
  assign accept     = rx_i.valid && rx_i.ready;

  // Frame position tracking
  always_comb begin
    receiving_d  = receiving_q;
    count_d      = count_q;
    len_ok_d     = len_ok_q;
    frame_d      = frame_q;
    push_o.valid = 1'b0;
    push_o.frame = frame_q;
    if (accept) begin
      if (!receiving_q) begin
        if (rx_i.rx_byte == StartByte) begin
          receiving_d = 1'b1;
          count_d     = CntW'(1);
        end
      end else if (rx_i.rx_byte == EndByte && len_ok_q &&
                   count_q == CntW'(TypeLength - 1)) begin
        // end byte at its slot closes the frame
        push_o.valid = 1'b1;
        receiving_d  = 1'b0;
        count_d      = '0;
        len_ok_d     = 1'b0;
      end else begin
        if (count_q == CntW'(1) && rx_i.rx_byte == TypeByte) begin
          len_ok_d = 1'b1;
        end
        if (count_q == CntW'(2)) frame_d.byte2 = rx_i.rx_byte;
        if (count_q == CntW'(3)) frame_d.byte3 = rx_i.rx_byte;
        if (count_q == CntW'(4)) frame_d.byte4 = rx_i.rx_byte;
        if (count_q == CntW'(BufferBytes - 1)) begin
          // overflow: drop the frame
          receiving_d = 1'b0;
          count_d     = '0;
          len_ok_d    = 1'b0;
        end else begin
          count_d = count_q + 1'b1;
        end
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      count_q     <= '0;
      len_ok_q    <= 1'b0;
    end else begin
      receiving_q <= receiving_d;
      count_q     <= count_d;
      len_ok_q    <= len_ok_d;
    end
  end

  // Captured frame bytes
  always_ff @(posedge clk_i) begin
    frame_q <= frame_d;
  end

  // Position count is nonzero exactly while a frame is open
  a_count_tracks_receiving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    receiving_q == (count_q != '0))
    else $error("frame count out of step with receiving flag");

  // Length is known only after the type byte has been stored
  a_len_after_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_ok_q |-> (receiving_q && count_q >= CntW'(2)))
    else $error("frame length set outside an open frame");

endmodule

// File: rtl/cfdd_queue.sv
// ----------------------------------------------------------------------------
// cfdd_queue
// Short queue of closed frames between deframer and decoder.
// ----------------------------------------------------------------------------
module cfdd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfdd_pkg::cfdd_push_t push_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output cfdd_pkg::cfdd_head_t head_o
);
  import cfdd_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned FillW = $clog2(QueueDepth + 1);

  cfdd_frame_t      mem_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d;
  logic [PtrW-1:0]  rptr_q, rptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o       = (fill_q == FillW'(QueueDepth));
  assign head_o.valid = (fill_q != '0);
  assign head_o.frame = mem_q[rptr_q];
  assign do_push      = push_i.valid;
  assign do_pop       = pop_i && head_o.valid;

  // Pointer and fill update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    fill_d = fill_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    unique case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + 1'b1;
      2'b01:   fill_d = fill_q - 1'b1;
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      fill_q <= fill_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_i.frame;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid |-> !full_o)
    else $error("frame pushed into a full queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillW'(QueueDepth))
    else $error("queue fill beyond depth");

endmodule

// File: rtl/cfdd_back.sv
// ----------------------------------------------------------------------------
// cfdd_back
// Decoder: applies a closed frame to battery, gear and speed state and
// registers the result word.
// ----------------------------------------------------------------------------
module cfdd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cfdd_pkg::cfdd_head_t head_i,
  output logic                 pop_o,
  cfdd_result_if.source        res_o
);
  import cfdd_pkg::*;

  logic         batt_one_q, batt_one_d;
  logic         batt_two_q, batt_two_d;
  logic [1:0]   choice_q, choice_d;
  logic [2:0]   gear_q, gear_d;
  logic [1:0]   speed_q, speed_d;
  logic         out_valid_q;
  cfdd_result_t out_q, out_d;
  logic [7:0]   cmd;
  logic [2:0]   gsel;
  logic [2:0]   vsel;

  assign pop_o       = head_i.valid && (!out_valid_q || res_o.ready);
  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_q;

  assign cmd  = head_i.frame.byte4;
  assign gsel = head_i.frame.byte3[2:0];
  assign vsel = head_i.frame.byte3[5:3];

  // Next state and result for the frame at the queue head
  always_comb begin
    batt_one_d = batt_one_q;
    batt_two_d = batt_two_q;
    choice_d   = choice_q;
    gear_d     = gear_q;
    speed_d    = speed_q;
    out_d      = out_q;

    // battery one request is handled before battery two
    if (cmd[BattOneBit]) begin
      if (!batt_one_d) begin
        batt_two_d = 1'b0;
        batt_one_d = 1'b1;
        choice_d   = BattOne;
      end else begin
        batt_one_d = 1'b0;
        choice_d   = BattNone;
      end
    end
    if (cmd[BattTwoBit]) begin
      if (!batt_two_d) begin
        batt_one_d = 1'b0;
        batt_two_d = 1'b1;
        choice_d   = BattTwo;
      end else begin
        batt_two_d = 1'b0;
        choice_d   = BattNone;
      end
    end

    // gear only moves while control is taken
    if (cmd[CtrlBit] && gsel >= GearLow && gsel <= GearHigh) begin
      gear_d = gsel;
    end

    out_d.speed_changed = 1'b1;
    priority if (vsel == VelSelTurtle) begin
      speed_d = SpeedTurtle;
    end else if (vsel == VelSelRabbit) begin
      speed_d = SpeedRabbit;
    end else if (vsel == VelSelLeopard) begin
      speed_d = SpeedLeopard;
    end else begin
      out_d.speed_changed = 1'b0;
    end

    out_d.interior_toggle   = cmd[InteriorBit];
    out_d.navigation_toggle = cmd[NavBit];
    out_d.battery_one_on    = batt_one_d;
    out_d.battery_two_on    = batt_two_d;
    out_d.battery_selected  = choice_d;
    out_d.battery_changed   = cmd[BattOneBit] || cmd[BattTwoBit];
    out_d.control_on        = cmd[CtrlBit];
    out_d.gear_now          = gear_d;
    out_d.neutral_seen      = (gsel == GearNeutral);
    out_d.speed_mode        = speed_d;
    out_d.wheel_direction   = head_i.frame.byte2;
  end

  // Decoder state and output word valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batt_one_q  <= 1'b0;
      batt_two_q  <= 1'b0;
      choice_q    <= BattNone;
      gear_q      <= '0;
      speed_q     <= SpeedTurtle;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        batt_one_q <= batt_one_d;
        batt_two_q <= batt_two_d;
        choice_q   <= choice_d;
        gear_q     <= gear_d;
        speed_q    <= speed_d;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= out_d;
    end
  end

  // A new word shows up only after a frame left the queue
  a_word_from_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(pop_o))
    else $error("result word without a decoded frame");

endmodule

// File: rtl/command_frame_deframer_decoder.sv
// ----------------------------------------------------------------------------
// command_frame_deframer_decoder
// Result path: a closed frame is queued; the decoder registers its word on pop.
// Throughput: one received byte per cycle; input stalls only while the
// two-entry frame queue is full behind a stalled result word.
// Reset: asynchronous, active low; clears framing, queue, battery, gear and
// speed state. No clearing pass is needed.
// ----------------------------------------------------------------------------
module command_frame_deframer_decoder #(
  parameter int unsigned BufferBytes = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cfdd_byte_if.sink      rx_i,
  cfdd_result_if.source  res_o
);
  import cfdd_pkg::*;

  cfdd_push_t push;
  cfdd_head_t head;
  logic       full;
  logic       pop;

  // Front: deframer
  cfdd_front #(
    .BufferBytes(BufferBytes)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_i),
    .full_i (full),
    .push_o (push)
  );

  // Frame queue
  cfdd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (full),
    .head_o (head)
  );

  // Back: decoder
  cfdd_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule
